### src/gwwb_pkg.sv
package gwwb_pkg;

   localparam int PIX_W       = 8;
   localparam int SUM_W       = 18;
   localparam int CNT_W       = 11;
   localparam int MAX_SAMPLES = 1024;
   localparam int CHANNELS    = 3;
   localparam int DIV_STEPS   = SUM_W;
   localparam int DIV_CNT_W   = 5;
   localparam int GAIN_W      = 11;   // signed working width of a gain during the step
   localparam int GAIN_RESET  = 64;

   // floor(x / 3) as (x * RECIP_3) >> RECIP_SHIFT, exact for x below 2048
   localparam int RECIP_3     = 683;
   localparam int RECIP_SHIFT = 11;
   localparam int RECIP_W     = 20;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_MARGIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_UNITY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_MAX        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MIN_BRIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MAX_BRIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MAX_DEV    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_REQUIRED   = 3'd6;

   typedef logic [1:0] chan_type;

   localparam chan_type CHAN_LAST = chan_type'(CHANNELS - 1);

   typedef struct packed {
      logic [PIX_W-1:0] settle_margin;
      logic [PIX_W-1:0] gain_unity;
      logic [PIX_W-1:0] gain_max;
      logic [PIX_W-1:0] gray_min_brightness;
      logic [PIX_W-1:0] gray_max_brightness;
      logic [PIX_W-1:0] gray_max_deviation_q8;
      logic [8:0]       gray_required_q8;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_SELECT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_AVERAGE,
      ST_NORMALISE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     select;
      logic     div_start;
      logic     div_store;
      chan_type chan;
      logic     average;
      logic     normalise;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic last_in_flight;
      logic div_busy;
   } status_type;

endpackage

### src/gwwb_csr.sv
module gwwb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gwwb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gwwb_pkg::CSR_DATA_W-1:0] csr_write_data,
   output gwwb_pkg::cfg_type                cfg
);

   gwwb_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gwwb_pkg::CSR_SETTLE_MARGIN:   cfg_in.settle_margin         = csr_write_data[7:0];
            gwwb_pkg::CSR_GAIN_UNITY:      cfg_in.gain_unity            = csr_write_data[7:0];
            gwwb_pkg::CSR_GAIN_MAX:        cfg_in.gain_max              = csr_write_data[7:0];
            gwwb_pkg::CSR_GRAY_MIN_BRIGHT: cfg_in.gray_min_brightness   = csr_write_data[7:0];
            gwwb_pkg::CSR_GRAY_MAX_BRIGHT: cfg_in.gray_max_brightness   = csr_write_data[7:0];
            gwwb_pkg::CSR_GRAY_MAX_DEV:    cfg_in.gray_max_deviation_q8 = csr_write_data[7:0];
            gwwb_pkg::CSR_GRAY_REQUIRED:   cfg_in.gray_required_q8      = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_margin         <= 8'd2;
         cfg_ff.gain_unity            <= 8'd64;
         cfg_ff.gain_max              <= 8'd255;
         cfg_ff.gray_min_brightness   <= 8'd10;
         cfg_ff.gray_max_brightness   <= 8'd253;
         cfg_ff.gray_max_deviation_q8 <= 8'd64;
         cfg_ff.gray_required_q8      <= 9'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/gwwb_ctrl.sv
module gwwb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 last_sample,
   input  gwwb_pkg::status_type status,
   output logic                 busy,
   output gwwb_pkg::cmd_type    cmd
);

   gwwb_pkg::state_type state_ff, state_in;
   gwwb_pkg::chan_type  chan_ff, chan_in;

   assign busy = (state_ff != gwwb_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      cmd           = '0;
      cmd.chan      = chan_ff;
      case (state_ff)
         gwwb_pkg::ST_IDLE: begin
            cmd.accept = start;
            if (start && last_sample) begin
               state_in = gwwb_pkg::ST_DRAIN;
            end
         end
         gwwb_pkg::ST_DRAIN: begin
            // wait for the last sample to reach the accumulators
            if (status.last_in_flight) begin
               state_in = gwwb_pkg::ST_SELECT;
            end
         end
         gwwb_pkg::ST_SELECT: begin
            cmd.select = 1'b1;
            chan_in    = '0;
            state_in   = gwwb_pkg::ST_DIV_START;
         end
         gwwb_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = gwwb_pkg::ST_DIV_WAIT;
         end
         gwwb_pkg::ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.div_store = 1'b1;
               if (chan_ff == gwwb_pkg::CHAN_LAST) begin
                  state_in = gwwb_pkg::ST_AVERAGE;
               end else begin
                  chan_in  = gwwb_pkg::chan_type'(chan_ff + 2'd1);
                  state_in = gwwb_pkg::ST_DIV_START;
               end
            end
         end
         gwwb_pkg::ST_AVERAGE: begin
            cmd.average = 1'b1;
            state_in    = gwwb_pkg::ST_NORMALISE;
         end
         gwwb_pkg::ST_NORMALISE: begin
            cmd.normalise = 1'b1;
            state_in      = gwwb_pkg::ST_EMIT;
         end
         gwwb_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = gwwb_pkg::ST_IDLE;
         end
         default: begin
            state_in = gwwb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwwb_pkg::ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

### src/gwwb_datapath.sv
module gwwb_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  gwwb_pkg::cmd_type            cmd,
   input  gwwb_pkg::cfg_type            cfg,
   input  logic [gwwb_pkg::PIX_W-1:0]   sample_red,
   input  logic [gwwb_pkg::PIX_W-1:0]   sample_green,
   input  logic [gwwb_pkg::PIX_W-1:0]   sample_blue,
   input  logic                         last_sample,
   output gwwb_pkg::status_type         status,
   output logic                         rsp_valid,
   output logic [gwwb_pkg::PIX_W-1:0]   rsp_gain_red,
   output logic [gwwb_pkg::PIX_W-1:0]   rsp_gain_green,
   output logic [gwwb_pkg::PIX_W-1:0]   rsp_gain_blue,
   output logic                         rsp_settled
);

   localparam int PW = gwwb_pkg::PIX_W;
   localparam int SW = gwwb_pkg::SUM_W;
   localparam int CW = gwwb_pkg::CNT_W;
   localparam int NC = gwwb_pkg::CHANNELS;
   localparam int GW = gwwb_pkg::GAIN_W;
   localparam int RW = gwwb_pkg::RECIP_W;
   localparam int RS = gwwb_pkg::RECIP_SHIFT;

   // ---------------- sample pipeline ----------------
   logic          s0_valid_ff, s0_valid_in;
   logic          s0_last_ff,  s0_last_in;
   logic [PW-1:0] s0_pix_ff [NC];
   logic [PW-1:0] s0_pix_in [NC];

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff,  s1_last_in;
   logic [PW-1:0] s1_pix_ff [NC];
   logic [PW-1:0] s1_pix_in [NC];
   logic [PW-1:0] s1_bright_ff, s1_bright_in;

   logic [9:0]    s0_sum;
   logic [RW-1:0] s0_bright_prod;

   always_comb begin
      s0_valid_in  = cmd.accept;
      s0_last_in   = last_sample;
      s0_pix_in[0] = sample_red;
      s0_pix_in[1] = sample_green;
      s0_pix_in[2] = sample_blue;

      s0_sum         = 10'(s0_pix_ff[0]) + 10'(s0_pix_ff[1]) + 10'(s0_pix_ff[2]);
      s0_bright_prod = RW'(s0_sum) * RW'(gwwb_pkg::RECIP_3);
      s1_valid_in    = s0_valid_ff;
      s1_last_in     = s0_last_ff;
      s1_bright_in   = s0_bright_prod[RS+PW-1:RS];
      for (int i = 0; i < NC; i++) begin
         s1_pix_in[i] = s0_pix_ff[i];
      end
   end

   // ---------------- near-gray test and accumulation ----------------
   logic [SW-1:0] chan_sum_ff [NC];
   logic [SW-1:0] chan_sum_in [NC];
   logic [SW-1:0] gray_sum_ff [NC];
   logic [SW-1:0] gray_sum_in [NC];
   logic [CW-1:0] frame_cnt_ff, frame_cnt_in;
   logic [CW-1:0] gray_cnt_ff,  gray_cnt_in;

   logic [PW-1:0]   dev [NC];
   logic [2*PW-1:0] dev_limit;
   logic            near_gray;
   logic            acc_en;

   always_comb begin
      dev_limit = (2*PW)'(cfg.gray_max_deviation_q8) * (2*PW)'(s1_bright_ff);
      near_gray = (s1_bright_ff >= cfg.gray_min_brightness) &&
                  (s1_bright_ff <= cfg.gray_max_brightness);
      for (int i = 0; i < NC; i++) begin
         dev[i] = (s1_pix_ff[i] > s1_bright_ff) ? (s1_pix_ff[i] - s1_bright_ff)
                                                : (s1_bright_ff - s1_pix_ff[i]);
         if (!({dev[i], 8'd0} < dev_limit)) begin
            near_gray = 1'b0;
         end
      end

      acc_en = s1_valid_ff && (frame_cnt_ff < CW'(gwwb_pkg::MAX_SAMPLES));

      frame_cnt_in = frame_cnt_ff;
      gray_cnt_in  = gray_cnt_ff;
      for (int i = 0; i < NC; i++) begin
         chan_sum_in[i] = chan_sum_ff[i];
         gray_sum_in[i] = gray_sum_ff[i];
      end

      if (cmd.emit) begin
         frame_cnt_in = '0;
         gray_cnt_in  = '0;
         for (int i = 0; i < NC; i++) begin
            chan_sum_in[i] = '0;
            gray_sum_in[i] = '0;
         end
      end else if (acc_en) begin
         frame_cnt_in = frame_cnt_ff + CW'(1);
         for (int i = 0; i < NC; i++) begin
            chan_sum_in[i] = chan_sum_ff[i] + SW'(s1_pix_ff[i]);
         end
         if (near_gray) begin
            gray_cnt_in = gray_cnt_ff + CW'(1);
            for (int i = 0; i < NC; i++) begin
               gray_sum_in[i] = gray_sum_ff[i] + SW'(s1_pix_ff[i]);
            end
         end
      end
   end

   // ---------------- mean selection and shared divider ----------------
   logic                         use_gray_ff, use_gray_in;
   logic [19:0]                  gray_scaled;
   logic [19:0]                  gray_needed;
   logic [SW-1:0]                div_q_ff, div_q_in;
   logic [CW-1:0]                div_rem_ff, div_rem_in;
   logic [CW-1:0]                div_den_ff, div_den_in;
   logic [gwwb_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CW:0]                  rem_shift;
   logic [CW:0]                  rem_diff;
   logic                         div_busy;
   logic [PW-1:0]                mean_ff [NC];
   logic [PW-1:0]                mean_in [NC];

   assign div_busy = (div_cnt_ff != '0);

   always_comb begin
      gray_scaled = 20'({gray_cnt_ff, 8'd0});
      gray_needed = 20'(cfg.gray_required_q8) * 20'(frame_cnt_ff);
      use_gray_in = use_gray_ff;
      if (cmd.select) begin
         use_gray_in = (gray_cnt_ff != '0) && (gray_scaled >= gray_needed);
      end

      rem_shift = {div_rem_ff, div_q_ff[SW-1]};
      rem_diff  = rem_shift - {1'b0, div_den_ff};

      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_q_in   = use_gray_ff ? gray_sum_ff[cmd.chan] : chan_sum_ff[cmd.chan];
         div_den_in = use_gray_ff ? gray_cnt_ff : frame_cnt_ff;
         div_rem_in = '0;
         div_cnt_in = gwwb_pkg::DIV_CNT_W'(gwwb_pkg::DIV_STEPS);
      end else if (div_busy) begin
         // one quotient bit a cycle, restoring form
         if (rem_shift >= {1'b0, div_den_ff}) begin
            div_rem_in = rem_diff[CW-1:0];
            div_q_in   = {div_q_ff[SW-2:0], 1'b1};
         end else begin
            div_rem_in = rem_shift[CW-1:0];
            div_q_in   = {div_q_ff[SW-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - gwwb_pkg::DIV_CNT_W'(1);
      end

      for (int i = 0; i < NC; i++) begin
         mean_in[i] = mean_ff[i];
      end
      // a mean never exceeds the largest sample value
      if (cmd.div_store) begin
         mean_in[cmd.chan] = div_q_ff[PW-1:0];
      end
   end

   // ---------------- average, normalise and gain step ----------------
   logic [PW-1:0] avg_ff, avg_in;
   logic [9:0]    mean_total;
   logic [RW-1:0] avg_prod;

   logic [PW-1:0] gains_ff [NC];
   logic [PW-1:0] gains_in [NC];
   logic [PW-1:0] gn_ff [NC];
   logic [PW-1:0] gn_in [NC];
   logic          raised_ff, raised_in;
   logic          raised;
   logic [PW-1:0] gain_min;
   logic [PW-1:0] norm_offset;

   always_comb begin
      mean_total = 10'(mean_ff[0]) + 10'(mean_ff[1]) + 10'(mean_ff[2]);
      avg_prod   = RW'(mean_total) * RW'(gwwb_pkg::RECIP_3);
      avg_in     = cmd.average ? avg_prod[RS+PW-1:RS] : avg_ff;

      raised = 1'b0;
      for (int i = 0; i < NC; i++) begin
         if (gains_ff[i] < cfg.gain_unity) begin
            raised = 1'b1;
         end
      end
      gain_min = gains_ff[0];
      if (gains_ff[1] < gain_min) gain_min = gains_ff[1];
      if (gains_ff[2] < gain_min) gain_min = gains_ff[2];
      norm_offset = (gain_min > cfg.gain_unity) ? (gain_min - cfg.gain_unity) : '0;

      raised_in = raised_ff;
      for (int i = 0; i < NC; i++) begin
         gn_in[i] = gn_ff[i];
      end
      if (cmd.normalise) begin
         raised_in = raised;
         for (int i = 0; i < NC; i++) begin
            if (raised) begin
               gn_in[i] = (gains_ff[i] < cfg.gain_unity) ? cfg.gain_unity : gains_ff[i];
            end else begin
               gn_in[i] = gains_ff[i] - norm_offset;
            end
         end
      end
   end

   logic                 balanced;
   logic                 all_above;
   logic                 unchanged;
   logic                 mean_gt [NC];
   logic                 mean_lt [NC];
   logic [PW-1:0]        abs_d [NC];
   logic [PW-1:0]        step_d [NC];
   logic signed [GW-1:0] g_step [NC];
   logic signed [GW-1:0] g_trim [NC];
   logic signed [GW-1:0] unity_s;
   logic signed [GW-1:0] max_s;
   logic [PW-1:0]        final_gain [NC];
   logic                 final_settled;

   always_comb begin
      unity_s  = signed'(GW'(cfg.gain_unity));
      max_s    = signed'(GW'(cfg.gain_max));
      balanced = 1'b1;
      for (int i = 0; i < NC; i++) begin
         mean_gt[i] = mean_ff[i] > avg_ff;
         mean_lt[i] = mean_ff[i] < avg_ff;
         abs_d[i]   = mean_gt[i] ? (mean_ff[i] - avg_ff) : (avg_ff - mean_ff[i]);
         step_d[i]  = ((abs_d[i] >> 2) == '0) ? PW'(1) : (abs_d[i] >> 2);
         if (!(abs_d[i] < cfg.settle_margin)) begin
            balanced = 1'b0;
         end
         g_step[i] = signed'(GW'(gn_ff[i]));
         if (mean_gt[i] && (gn_ff[i] > cfg.gain_unity)) begin
            g_step[i] = g_step[i] - signed'(GW'(step_d[i]));
         end
         if (mean_lt[i] && (gn_ff[i] < cfg.gain_max)) begin
            g_step[i] = g_step[i] + signed'(GW'(step_d[i]));
         end
      end

      all_above = (g_step[0] > unity_s) && (g_step[1] > unity_s) && (g_step[2] > unity_s);

      unchanged = 1'b1;
      for (int i = 0; i < NC; i++) begin
         g_trim[i] = all_above ? (g_step[i] - signed'(GW'(1))) : g_step[i];
         if (raised_ff) begin
            final_gain[i] = gn_ff[i];
         end else if (balanced) begin
            final_gain[i] = (gn_ff[i] > cfg.gain_max) ? cfg.gain_max : gn_ff[i];
         end else if (g_trim[i] < signed'(GW'(0))) begin
            final_gain[i] = '0;
         end else if (g_trim[i] > max_s) begin
            final_gain[i] = cfg.gain_max;
         end else begin
            final_gain[i] = g_trim[i][PW-1:0];
         end
         if (final_gain[i] != gains_ff[i]) begin
            unchanged = 1'b0;
         end
      end

      if (raised_ff) begin
         final_settled = 1'b0;
      end else if (balanced) begin
         final_settled = 1'b1;
      end else begin
         final_settled = unchanged;
      end

      for (int i = 0; i < NC; i++) begin
         gains_in[i] = cmd.emit ? final_gain[i] : gains_ff[i];
      end
   end

   // ---------------- result register ----------------
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_gain_ff [NC];
   logic [PW-1:0] rsp_gain_in [NC];
   logic          rsp_settled_ff, rsp_settled_in;

   always_comb begin
      rsp_valid_in   = cmd.emit;
      rsp_settled_in = cmd.emit ? final_settled : rsp_settled_ff;
      for (int i = 0; i < NC; i++) begin
         rsp_gain_in[i] = cmd.emit ? final_gain[i] : rsp_gain_ff[i];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_gain_red          = rsp_gain_ff[0];
   assign rsp_gain_green        = rsp_gain_ff[1];
   assign rsp_gain_blue         = rsp_gain_ff[2];
   assign rsp_settled           = rsp_settled_ff;
   assign status.last_in_flight = s1_valid_ff && s1_last_ff;
   assign status.div_busy       = div_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         frame_cnt_ff <= '0;
         gray_cnt_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            chan_sum_ff[i] <= '0;
            gray_sum_ff[i] <= '0;
            gains_ff[i]    <= PW'(gwwb_pkg::GAIN_RESET);
         end
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         frame_cnt_ff <= frame_cnt_in;
         gray_cnt_ff  <= gray_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NC; i++) begin
            chan_sum_ff[i] <= chan_sum_in[i];
            gray_sum_ff[i] <= gray_sum_in[i];
            gains_ff[i]    <= gains_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      s0_last_ff     <= s0_last_in;
      s1_last_ff     <= s1_last_in;
      s1_bright_ff   <= s1_bright_in;
      use_gray_ff    <= use_gray_in;
      div_q_ff       <= div_q_in;
      div_rem_ff     <= div_rem_in;
      div_den_ff     <= div_den_in;
      avg_ff         <= avg_in;
      raised_ff      <= raised_in;
      rsp_settled_ff <= rsp_settled_in;
      for (int i = 0; i < NC; i++) begin
         s0_pix_ff[i]   <= s0_pix_in[i];
         s1_pix_ff[i]   <= s1_pix_in[i];
         mean_ff[i]     <= mean_in[i];
         gn_ff[i]       <= gn_in[i];
         rsp_gain_ff[i] <= rsp_gain_in[i];
      end
   end

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while running");

   a_gray_count: assert property (@(posedge clock) disable iff (reset)
      gray_cnt_ff <= frame_cnt_ff)
      else $error("near-gray count exceeds frame count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      frame_cnt_ff <= CW'(gwwb_pkg::MAX_SAMPLES))
      else $error("frame count beyond sample limit");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!s0_valid_ff && !s1_valid_ff && !div_busy))
      else $error("result issued with samples or a division in flight");
`endif

endmodule

### src/gray_world_white_balance.sv
// Gray-world white balance. Sample points are taken one per cycle whenever busy is low
// (start high, busy low), through a two-stage brightness and near-gray pipeline into the
// frame accumulators. A sample marked last_sample ends the frame: busy then stays high
// while the sample pipeline drains, near-gray or all-sample means are chosen, the three
// channel means pass in turn through one shared restoring divider that produces a
// quotient bit per cycle, and the average, normalise and gain step states follow.
// The result is shown for exactly one cycle with rsp_valid, in the first cycle busy is
// low again; the receiver cannot stall it, so it must capture the gains on that strobe.
// Only the frame-end sample gives a result. Configuration writes are always ready and
// belong between frames.
module gray_world_white_balance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [gwwb_pkg::PIX_W-1:0]      req_sample_red,
   input  logic [gwwb_pkg::PIX_W-1:0]      req_sample_green,
   input  logic [gwwb_pkg::PIX_W-1:0]      req_sample_blue,
   input  logic                             req_last_sample,
   output logic                             rsp_valid,
   output logic [gwwb_pkg::PIX_W-1:0]      rsp_gain_red,
   output logic [gwwb_pkg::PIX_W-1:0]      rsp_gain_green,
   output logic [gwwb_pkg::PIX_W-1:0]      rsp_gain_blue,
   output logic                             rsp_settled,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gwwb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gwwb_pkg::CSR_DATA_W-1:0] csr_write_data
);

   gwwb_pkg::cfg_type    cfg;
   gwwb_pkg::cmd_type    cmd;
   gwwb_pkg::status_type status;

   gwwb_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   gwwb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_sample (req_last_sample),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   gwwb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .sample_red     (req_sample_red),
      .sample_green   (req_sample_green),
      .sample_blue    (req_sample_blue),
      .last_sample    (req_last_sample),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_gain_red   (rsp_gain_red),
      .rsp_gain_green (rsp_gain_green),
      .rsp_gain_blue  (rsp_gain_blue),
      .rsp_settled    (rsp_settled)
   );

endmodule
